// ===== sv/ppp_link_event_automaton_defines.svh =====
// Assertion macros shared by the link automaton.
`ifndef PPP_LINK_EVENT_AUTOMATON_DEFINES_SVH
`define PPP_LINK_EVENT_AUTOMATON_DEFINES_SVH

// Checked at every edge outside reset.
`define PPLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define PPLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/pple_pkg.sv =====
package pple_pkg;

  // Field and counter widths.
  localparam int CntW    = 15;
  localparam int StateW  = 4;
  localparam int ActionW = 4;
  localparam int CfgIdxW = 1;

  // Register reset values.
  localparam logic [CntW-1:0] MaxConfRst = 15'd10;
  localparam logic [CntW-1:0] MaxTermRst = 15'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MAX_CONFIGURE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TERMINATE = 1'b1;

  // Automaton states in RFC order.
  localparam logic [StateW-1:0] ST_INITIAL  = 4'd0;
  localparam logic [StateW-1:0] ST_STARTING = 4'd1;
  localparam logic [StateW-1:0] ST_CLOSED   = 4'd2;
  localparam logic [StateW-1:0] ST_STOPPED  = 4'd3;
  localparam logic [StateW-1:0] ST_CLOSING  = 4'd4;
  localparam logic [StateW-1:0] ST_STOPPING = 4'd5;
  localparam logic [StateW-1:0] ST_REQSENT  = 4'd6;
  localparam logic [StateW-1:0] ST_ACKRCVD  = 4'd7;
  localparam logic [StateW-1:0] ST_ACKSENT  = 4'd8;
  localparam logic [StateW-1:0] ST_OPENED   = 4'd9;

  // Event codes.
  localparam logic [ActionW-1:0] ACT_UP          = 4'd0;
  localparam logic [ActionW-1:0] ACT_DOWN        = 4'd1;
  localparam logic [ActionW-1:0] ACT_OPEN        = 4'd2;
  localparam logic [ActionW-1:0] ACT_CLOSE       = 4'd3;
  localparam logic [ActionW-1:0] ACT_TIMEOUT     = 4'd4;
  localparam logic [ActionW-1:0] ACT_RESET       = 4'd5;
  localparam logic [ActionW-1:0] ACT_REC_DEFAULT = 4'd6;
  localparam logic [ActionW-1:0] ACT_REC_PERSIST = 4'd7;
  localparam logic [ActionW-1:0] ACT_REC_PASSIVE = 4'd8;
  localparam logic [ActionW-1:0] ACT_AUTH_DONE   = 4'd9;

  // One input beat.
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic               phy_ready;
    logic               phy_attached;
    logic               auth_pending;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic [StateW-1:0] link_state;
    logic              send_conf_req;
    logic              send_term_req;
    logic              start_negotiation;
    logic              phy_up_req;
    logic              phy_down_req;
    logic              layer_up;
    logic              layer_down;
    logic              rearm_timer;
    logic              running;
    logic [CntW-1:0]   restarts_left;
    logic              status;
  } out_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

// ===== sv/pple_ctrl.sv =====
module pple_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic          done_o,
  output pple_pkg::cmd_t cmd_o
);

  localparam logic CtlIdle = 1'b0;
  localparam logic CtlExec = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;

  // Capture in idle, evaluate in the following cycle.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    case (state_q)
      CtlIdle: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CtlExec;
        end
      end
      CtlExec: begin
        cmd_o.exec = 1'b1;
        state_d    = CtlIdle;
      end
      default: state_d = CtlIdle;
    endcase
    done_d = cmd_o.exec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q == CtlExec);
  assign done_o = done_q;

endmodule

// ===== sv/pple_datapath.sv =====
module pple_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pple_pkg::cmd_t                cmd_i,
  input  pple_pkg::in_t                 in_i,
  input  logic                          cfg_we_i,
  input  logic [pple_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pple_pkg::CntW-1:0]     cfg_data_i,
  output pple_pkg::out_t                out_o
);

  // Working copy of the automaton while one event is evaluated.
  typedef struct packed {
    logic [pple_pkg::StateW-1:0] st;
    logic [pple_pkg::CntW-1:0]   cnt;
    logic                        per;
    logic                        pas;
    logic                        lup;
    logic                        conf;
    logic                        term;
    logic                        neg;
    logic                        phyup;
    logic                        phydn;
    logic                        lup_stb;
    logic                        ldn;
    logic                        rearm;
    logic                        status;
  } ev_t;

  logic [pple_pkg::StateW-1:0] st_q;
  logic [pple_pkg::CntW-1:0]   cnt_q;
  logic                        per_q, pas_q, lup_q;
  logic [pple_pkg::CntW-1:0]   max_conf_q, max_term_q;
  pple_pkg::in_t               in_q;
  pple_pkg::out_t              out_q, out_d;
  ev_t                         ev;

  // State change with the layer up and down side effects.
  function automatic ev_t go_state(ev_t e, logic [pple_pkg::StateW-1:0] ns, logic auth);
    ev_t r;
    r = e;
    if (e.st != pple_pkg::ST_OPENED && ns == pple_pkg::ST_OPENED && !auth) begin
      r.lup_stb = 1'b1;
      r.lup     = 1'b1;
    end
    if (e.st == pple_pkg::ST_OPENED && ns != pple_pkg::ST_OPENED) begin
      r.ldn = 1'b1;
      r.lup = 1'b0;
    end
    r.st = ns;
    return r;
  endfunction

  // Each request sent counts down, holding at zero.
  function automatic logic [pple_pkg::CntW-1:0] dec_sat(logic [pple_pkg::CntW-1:0] c);
    return (c != '0) ? c - pple_pkg::CntW'(1) : c;
  endfunction

  function automatic ev_t send_conf(ev_t e);
    ev_t r;
    r      = e;
    r.conf = 1'b1;
    r.cnt  = dec_sat(e.cnt);
    return r;
  endfunction

  function automatic ev_t send_term(ev_t e);
    ev_t r;
    r      = e;
    r.term = 1'b1;
    r.cnt  = dec_sat(e.cnt);
    return r;
  endfunction

  function automatic ev_t begin_neg(ev_t e, logic [pple_pkg::CntW-1:0] maxc, logic auth);
    ev_t r;
    r     = e;
    r.neg = 1'b1;
    r.cnt = maxc;
    r     = send_conf(r);
    r     = go_state(r, pple_pkg::ST_REQSENT, auth);
    return r;
  endfunction

  function automatic ev_t ev_open(ev_t e, logic ready, logic [pple_pkg::CntW-1:0] maxc,
                                  logic auth);
    ev_t r;
    r = e;
    case (e.st)
      pple_pkg::ST_INITIAL: begin
        r.phyup = 1'b1;
        if (ready) begin
          r = begin_neg(r, maxc, auth);
        end else begin
          r = go_state(r, pple_pkg::ST_STARTING, auth);
        end
      end
      pple_pkg::ST_CLOSED, pple_pkg::ST_STOPPED,
      pple_pkg::ST_CLOSING, pple_pkg::ST_STOPPING: begin
        r = begin_neg(r, maxc, auth);
      end
      default: r = e;
    endcase
    return r;
  endfunction

  // Evaluate the captured event against the current automaton.
  always_comb begin
    ev        = '0;
    ev.st     = st_q;
    ev.cnt    = cnt_q;
    ev.per    = per_q;
    ev.pas    = pas_q;
    ev.lup    = lup_q;
    case (in_q.action)
      pple_pkg::ACT_UP: begin
        if (ev.st == pple_pkg::ST_INITIAL) begin
          if (ev.per) begin
            ev = begin_neg(ev, max_conf_q, in_q.auth_pending);
          end
          if (ev.pas) begin
            ev = go_state(ev, pple_pkg::ST_STOPPED, in_q.auth_pending);
          end
        end else if (ev.st == pple_pkg::ST_STARTING) begin
          ev = begin_neg(ev, max_conf_q, in_q.auth_pending);
        end else if (ev.st == pple_pkg::ST_STOPPED && ev.per) begin
          ev = begin_neg(ev, max_conf_q, in_q.auth_pending);
        end
      end
      pple_pkg::ACT_DOWN: begin
        if (ev.per) begin
          ev       = go_state(ev, pple_pkg::ST_STARTING, in_q.auth_pending);
          ev.phyup = 1'b1;
        end else begin
          ev       = go_state(ev, pple_pkg::ST_INITIAL, in_q.auth_pending);
          ev.phydn = 1'b1;
        end
      end
      pple_pkg::ACT_OPEN: begin
        if (in_q.phy_attached) begin
          ev = ev_open(ev, in_q.phy_ready, max_conf_q, in_q.auth_pending);
        end
      end
      pple_pkg::ACT_CLOSE: begin
        if (in_q.phy_attached) begin
          ev.per = 1'b0;
          ev.pas = 1'b0;
          case (ev.st)
            pple_pkg::ST_INITIAL, pple_pkg::ST_STARTING: begin
              ev.phydn = 1'b1;
              ev       = go_state(ev, pple_pkg::ST_INITIAL, in_q.auth_pending);
            end
            pple_pkg::ST_CLOSED, pple_pkg::ST_STOPPED: begin
              ev.phydn = 1'b1;
              ev       = go_state(ev, pple_pkg::ST_CLOSED, in_q.auth_pending);
            end
            pple_pkg::ST_CLOSING, pple_pkg::ST_STOPPING: begin
              ev = go_state(ev, pple_pkg::ST_CLOSING, in_q.auth_pending);
            end
            default: begin
              ev.cnt = max_term_q;
              ev     = send_term(ev);
              ev     = go_state(ev, pple_pkg::ST_CLOSING, in_q.auth_pending);
            end
          endcase
        end
      end
      pple_pkg::ACT_TIMEOUT: begin
        case (ev.st)
          pple_pkg::ST_STOPPED: begin
            if (ev.per) begin
              ev = begin_neg(ev, max_conf_q, in_q.auth_pending);
            end
          end
          pple_pkg::ST_CLOSING: begin
            if (ev.cnt != '0) begin
              ev = send_term(ev);
            end else begin
              ev       = go_state(ev, pple_pkg::ST_CLOSED, in_q.auth_pending);
              ev.phydn = 1'b1;
            end
          end
          pple_pkg::ST_STOPPING: begin
            if (ev.cnt != '0) begin
              ev = send_term(ev);
            end else begin
              ev = go_state(ev, pple_pkg::ST_STOPPED, in_q.auth_pending);
              if (ev.per) begin
                ev.rearm = 1'b1;
              end else if (!ev.pas) begin
                ev.phydn = 1'b1;
              end
            end
          end
          pple_pkg::ST_REQSENT, pple_pkg::ST_ACKSENT: begin
            // Configure timer expiry: resend or give up.
            if (ev.cnt != '0 || ev.per) begin
              ev = send_conf(ev);
            end else begin
              ev = go_state(ev, pple_pkg::ST_STOPPED, in_q.auth_pending);
              if (!ev.pas) begin
                ev.phydn = 1'b1;
              end
            end
          end
          pple_pkg::ST_ACKRCVD: begin
            ev.cnt = max_conf_q;
            ev     = send_conf(ev);
            ev     = go_state(ev, pple_pkg::ST_REQSENT, in_q.auth_pending);
          end
          default: ev.st = st_q;
        endcase
      end
      pple_pkg::ACT_RESET: begin
        // The counter is kept; everything else returns to its reset value.
        if (ev.st == pple_pkg::ST_OPENED) begin
          ev.ldn = 1'b1;
        end
        ev.st  = pple_pkg::ST_INITIAL;
        ev.per = 1'b0;
        ev.pas = 1'b0;
        ev.lup = 1'b0;
      end
      pple_pkg::ACT_REC_DEFAULT: begin
        ev.per = 1'b0;
        ev.pas = 1'b0;
      end
      pple_pkg::ACT_REC_PERSIST: begin
        ev.per = 1'b1;
        ev.pas = 1'b0;
        if (in_q.phy_attached) begin
          ev = ev_open(ev, in_q.phy_ready, max_conf_q, in_q.auth_pending);
        end
      end
      pple_pkg::ACT_REC_PASSIVE: begin
        ev.pas = 1'b1;
        ev.per = 1'b0;
        if (ev.st == pple_pkg::ST_INITIAL && in_q.phy_attached && in_q.phy_ready) begin
          ev = go_state(ev, pple_pkg::ST_STOPPED, in_q.auth_pending);
        end
      end
      pple_pkg::ACT_AUTH_DONE: begin
        if (ev.st == pple_pkg::ST_OPENED) begin
          if (!ev.lup) begin
            ev.lup_stb = 1'b1;
            ev.lup     = 1'b1;
          end
        end else begin
          ev.status = 1'b1;
        end
      end
      default: ev.st = st_q;
    endcase
  end

  // Result beat assembled from the evaluated event.
  always_comb begin
    out_d.link_state        = ev.st;
    out_d.send_conf_req     = ev.conf;
    out_d.send_term_req     = ev.term;
    out_d.start_negotiation = ev.neg;
    out_d.phy_up_req        = ev.phyup;
    out_d.phy_down_req      = ev.phydn;
    out_d.layer_up          = ev.lup_stb;
    out_d.layer_down        = ev.ldn;
    out_d.rearm_timer       = ev.rearm;
    out_d.running           = (ev.st != pple_pkg::ST_INITIAL);
    out_d.restarts_left     = ev.cnt;
    out_d.status            = ev.status;
  end

  // Automaton state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= pple_pkg::ST_INITIAL;
      cnt_q      <= '0;
      per_q      <= 1'b0;
      pas_q      <= 1'b0;
      lup_q      <= 1'b0;
      max_conf_q <= pple_pkg::MaxConfRst;
      max_term_q <= pple_pkg::MaxTermRst;
    end else begin
      if (cmd_i.exec) begin
        st_q  <= ev.st;
        cnt_q <= ev.cnt;
        per_q <= ev.per;
        pas_q <= ev.pas;
        lup_q <= ev.lup;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pple_pkg::CFG_MAX_CONFIGURE: max_conf_q <= cfg_data_i;
          pple_pkg::CFG_MAX_TERMINATE: max_term_q <= cfg_data_i;
          default: max_conf_q <= max_conf_q;
        endcase
      end
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_i;
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ===== sv/ppp_link_event_automaton.sv =====
// PPP link automaton for the non-packet events of RFC 1661. An event is taken
// when start is high while busy is low; busy then stays high for one cycle
// while the event is evaluated, and the result beat appears on out_o with
// done_o high for exactly one cycle after that. Results cannot be held off, so
// the receiver must take every beat in the cycle it is shown. Each event passes
// through the capture and evaluate steps of the sequencer; a new event may be
// started in the same cycle in which the previous result is shown.
// Configuration writes take effect at once and belong between events.
`include "ppp_link_event_automaton_defines.svh"

module ppp_link_event_automaton (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  pple_pkg::in_t                in_i,
  output logic                         done_o,
  output pple_pkg::out_t               out_o,
  input  logic                         cfg_we_i,
  input  logic [pple_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pple_pkg::CntW-1:0]    cfg_data_i
);

  pple_pkg::cmd_t cmd;

  // Event sequencer.
  pple_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // Automaton state, counter and event evaluation.
  pple_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_o      (out_o)
  );

  // An accepted event is evaluated in the next cycle and shown in the one after.
  `PPLE_ASSERT(a_accept_busy, (start && !busy) |=> busy,
    "accepted event did not raise busy")
  `PPLE_ASSERT(a_busy_done, busy |=> (done_o && !busy),
    "evaluation gave no result beat")
  `PPLE_ASSERT(a_running,
    done_o |-> (out_o.running == (out_o.link_state != pple_pkg::ST_INITIAL)),
    "running flag disagrees with state")
  `PPLE_ASSERT(a_conf_state,
    (done_o && out_o.send_conf_req) |-> (out_o.link_state == pple_pkg::ST_REQSENT ||
      out_o.link_state == pple_pkg::ST_ACKSENT),
    "configure request outside a negotiating state")
  `PPLE_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !done_o, "result beat during reset")

endmodule
